// ===== design/dwc3_pkg.sv =====
// ----------------------------------------------------------------------------
// dwc3_pkg
// Shared types, register indexes and the sequencer program for the 3x3
// depthwise convolution plane unit.
// ----------------------------------------------------------------------------
package dwc3_pkg;

    localparam int TAPS    = 3;
    localparam int DIM_W   = 7;    // width of the geometry registers
    localparam int IDX_W   = 2 * DIM_W;
    localparam int POS_W   = 7;    // internal output position counters
    localparam int ROW_W   = 6;    // output row and column fields
    localparam int SAMP_W  = 16;
    localparam int PROD_W  = 2 * SAMP_W;
    localparam int SUM_W   = 35;
    localparam int WROW_W  = TAPS * SAMP_W;
    localparam int CIDX_W  = 4;
    localparam int STEP_W  = 4;

    localparam logic [CIDX_W-1:0] CFG_IMAGE_WIDTH  = 4'd0;
    localparam logic [CIDX_W-1:0] CFG_IMAGE_HEIGHT = 4'd1;
    localparam logic [CIDX_W-1:0] CFG_STRIDE_SEL   = 4'd2;
    localparam logic [CIDX_W-1:0] CFG_PAD_ROWS     = 4'd3;
    localparam logic [CIDX_W-1:0] CFG_PAD_COLS     = 4'd4;
    localparam logic [CIDX_W-1:0] CFG_WEIGHT_ROW0  = 4'd5;
    localparam logic [CIDX_W-1:0] CFG_WEIGHT_ROW1  = 4'd6;
    localparam logic [CIDX_W-1:0] CFG_WEIGHT_ROW2  = 4'd7;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_COMPUTE = 1'b1;

    localparam logic [1:0] STRIDE_TWO = 2'd2;
    localparam logic [1:0] PAD_MAX    = 2'd2;

    localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;

    typedef struct packed {
        logic                     kind;
        logic signed [SAMP_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic signed [SUM_W-1:0] out_value;
        logic [ROW_W-1:0]        out_row;
        logic [ROW_W-1:0]        out_col;
        logic                    last;
    } t_out_item;

    typedef enum logic [1:0] {
        JMP_NEXT       = 2'd0,
        JMP_WAIT_START = 2'd1,
        JMP_WAIT_OUT   = 2'd2,
        JMP_HOME       = 2'd3
    } t_jump;

    typedef struct packed {
        logic       accept;
        logic       rd;
        logic [1:0] tap_i;
        logic [1:0] tap_j;
        logic       mul;
        logic       acc;
        logic       emit;
        t_jump      jump;
    } t_ctrl_word;

    // Program: idle/accept, nine reads, two steps to drain the multiply and
    // accumulate stages, then hand the sum to the output register.
    function automatic t_ctrl_word f_program(input logic [STEP_W-1:0] step);
        t_ctrl_word w;
        w      = '0;
        w.jump = JMP_NEXT;
        w.mul  = (step >= 4'd2) && (step <= 4'd10);
        w.acc  = (step >= 4'd3) && (step <= 4'd11);
        case (step)
            4'd0: begin
                w.accept = 1'b1;
                w.jump   = JMP_WAIT_START;
            end
            4'd1: begin w.rd = 1'b1; w.tap_i = 2'd0; w.tap_j = 2'd0; end
            4'd2: begin w.rd = 1'b1; w.tap_i = 2'd0; w.tap_j = 2'd1; end
            4'd3: begin w.rd = 1'b1; w.tap_i = 2'd0; w.tap_j = 2'd2; end
            4'd4: begin w.rd = 1'b1; w.tap_i = 2'd1; w.tap_j = 2'd0; end
            4'd5: begin w.rd = 1'b1; w.tap_i = 2'd1; w.tap_j = 2'd1; end
            4'd6: begin w.rd = 1'b1; w.tap_i = 2'd1; w.tap_j = 2'd2; end
            4'd7: begin w.rd = 1'b1; w.tap_i = 2'd2; w.tap_j = 2'd0; end
            4'd8: begin w.rd = 1'b1; w.tap_i = 2'd2; w.tap_j = 2'd1; end
            4'd9: begin w.rd = 1'b1; w.tap_i = 2'd2; w.tap_j = 2'd2; end
            4'd10, 4'd11: begin
                w.rd = 1'b0;
            end
            4'd12: begin
                w.emit = 1'b1;
                w.jump = JMP_WAIT_OUT;
            end
            default: begin
                w.jump = JMP_HOME;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== design/dwc3_ram.sv =====
// ----------------------------------------------------------------------------
// dwc3_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module dwc3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/dwc3_seq.sv =====
// ----------------------------------------------------------------------------
// dwc3_seq
// Step counter and program store; issues one control word per cycle.
// ----------------------------------------------------------------------------
module dwc3_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_out_free,
    output dwc3_pkg::t_ctrl_word o_ctrl
);

    logic [dwc3_pkg::STEP_W-1:0] r_step;
    logic [dwc3_pkg::STEP_W-1:0] n_step;
    dwc3_pkg::t_ctrl_word        ctrl;

    assign ctrl = dwc3_pkg::f_program(r_step);

    always_comb begin
        unique case (ctrl.jump)
            dwc3_pkg::JMP_NEXT:       n_step = r_step + 1'b1;
            dwc3_pkg::JMP_WAIT_START: n_step = i_start ? r_step + 1'b1 : r_step;
            dwc3_pkg::JMP_WAIT_OUT:   n_step = i_out_free ? dwc3_pkg::STEP_IDLE : r_step;
            dwc3_pkg::JMP_HOME:       n_step = dwc3_pkg::STEP_IDLE;
            default:                  n_step = dwc3_pkg::STEP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= dwc3_pkg::STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl = ctrl;

endmodule

// ===== design/depthwise_conv3x3_plane_unit.sv =====
// ----------------------------------------------------------------------------
// depthwise_conv3x3_plane_unit
// A load transaction is written to the frame store in the cycle it is accepted. A compute
// transaction makes nine store reads, one per cycle through the single read port, into
// one shared multiply-add, and its sum then goes to the output register; the next
// transaction is accepted only after that hand-over, which waits while the output
// register is not free. A new transaction is accepted while a finished result waits.
// Synchronous active-low reset clears control state and restores the register
// defaults; the frame store is not cleared.
// ----------------------------------------------------------------------------
module depthwise_conv3x3_plane_unit #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  dwc3_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output dwc3_pkg::t_out_item           o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dwc3_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [dwc3_pkg::WROW_W-1:0]   i_cfg_data
);

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int DIM_W       = dwc3_pkg::DIM_W;
    localparam int IDX_W       = dwc3_pkg::IDX_W;
    localparam int POS_W       = dwc3_pkg::POS_W;
    localparam int SAMP_W      = dwc3_pkg::SAMP_W;
    localparam int PROD_W      = dwc3_pkg::PROD_W;
    localparam int SUM_W       = dwc3_pkg::SUM_W;
    localparam int ROW_W       = dwc3_pkg::ROW_W;
    localparam int WROW_W      = dwc3_pkg::WROW_W;
    localparam int RC_W        = DIM_W + 3;

    // Configuration registers
    logic [DIM_W-1:0]  r_image_width;
    logic [DIM_W-1:0]  r_image_height;
    logic [1:0]        r_stride_sel;
    logic [1:0]        r_pad_rows;
    logic [1:0]        r_pad_cols;
    logic [WROW_W-1:0] r_weight [dwc3_pkg::TAPS];

    logic [IDX_W-1:0]  r_load_ptr;
    logic [POS_W-1:0]  r_row;
    logic [POS_W-1:0]  r_col;

    logic                       r_tap_valid;
    logic [1:0]                 r_tap_i;
    logic [1:0]                 r_tap_j;
    logic signed [PROD_W-1:0]   r_product;
    logic signed [SUM_W-1:0]    r_acc;
    logic                       r_out_valid;
    dwc3_pkg::t_out_item        r_out;

    dwc3_pkg::t_ctrl_word ctrl;

    logic [DIM_W-1:0] w_dim;
    logic [DIM_W-1:0] h_dim;
    logic             stride2;
    logic [1:0]       pr;
    logic [1:0]       pc;
    logic [DIM_W:0]   tot_r;
    logic [DIM_W:0]   tot_c;
    logic             empty;
    logic [DIM_W:0]   span_r;
    logic [DIM_W:0]   span_c;
    logic [POS_W-1:0] oh_m1;
    logic [POS_W-1:0] ow_m1;
    logic [IDX_W-1:0] plane;

    logic             in_accept;
    logic             do_load;
    logic             start;
    logic             out_free;
    logic             emit;
    logic             last;

    logic [IDX_W-1:0]    ld_addr;
    logic [IDX_W-1:0]    ld_next;
    logic [IDX_W+AW-1:0] waddr_wide;
    logic [AW-1:0]       waddr;

    logic [POS_W:0]           rs;
    logic [POS_W:0]           cs;
    logic signed [RC_W-1:0]   tap_r;
    logic signed [RC_W-1:0]   tap_c;
    logic                     tap_ok;
    logic [IDX_W-1:0]         rd_idx;
    logic [IDX_W+AW-1:0]      raddr_wide;
    logic [AW-1:0]            raddr;

    logic signed [SAMP_W-1:0] rdata;
    logic [WROW_W-1:0]        wrow;
    logic signed [SAMP_W-1:0] weight;
    logic signed [PROD_W-1:0] product;

    // ------------------------------------------------------------------
    // Geometry: clamped sizes, padding and output plane extent
    // ------------------------------------------------------------------
    always_comb begin
        if (r_image_width == '0) begin
            w_dim = DIM_W'(1);
        end else if (32'(r_image_width) > MAX_WIDTH) begin
            w_dim = DIM_W'(MAX_WIDTH);
        end else begin
            w_dim = r_image_width;
        end
        if (r_image_height == '0) begin
            h_dim = DIM_W'(1);
        end else if (32'(r_image_height) > MAX_HEIGHT) begin
            h_dim = DIM_W'(MAX_HEIGHT);
        end else begin
            h_dim = r_image_height;
        end
    end

    assign stride2 = (r_stride_sel == dwc3_pkg::STRIDE_TWO);
    assign pr      = (r_pad_rows > dwc3_pkg::PAD_MAX) ? dwc3_pkg::PAD_MAX : r_pad_rows;
    assign pc      = (r_pad_cols > dwc3_pkg::PAD_MAX) ? dwc3_pkg::PAD_MAX : r_pad_cols;
    assign tot_r   = {1'b0, h_dim} + (DIM_W+1)'(pr);
    assign tot_c   = {1'b0, w_dim} + (DIM_W+1)'(pc);
    assign empty   = (tot_r < (DIM_W+1)'(3)) || (tot_c < (DIM_W+1)'(3));
    assign span_r  = tot_r - (DIM_W+1)'(3);
    assign span_c  = tot_c - (DIM_W+1)'(3);
    assign oh_m1   = stride2 ? POS_W'(span_r >> 1) : POS_W'(span_r);
    assign ow_m1   = stride2 ? POS_W'(span_c >> 1) : POS_W'(span_c);
    assign plane   = IDX_W'(w_dim) * IDX_W'(h_dim);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign in_accept = i_in_valid && ctrl.accept;
    assign do_load   = in_accept && (i_in_data.kind == dwc3_pkg::KIND_LOAD);
    assign start     = in_accept && (i_in_data.kind == dwc3_pkg::KIND_COMPUTE) && !empty;
    assign out_free  = !r_out_valid || i_out_ready;
    assign emit      = ctrl.emit && out_free;

    dwc3_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_out_free (out_free),
        .o_ctrl     (ctrl)
    );

    // ------------------------------------------------------------------
    // Frame store
    // ------------------------------------------------------------------
    assign ld_addr    = (r_load_ptr < plane) ? r_load_ptr : '0;
    assign ld_next    = ld_addr + 1'b1;
    assign waddr_wide = {{AW{1'b0}}, ld_addr};
    assign waddr      = waddr_wide[AW-1:0];

    // Tap position relative to the image; taps in the padding read as zero.
    assign rs     = stride2 ? {r_row, 1'b0} : {1'b0, r_row};
    assign cs     = stride2 ? {r_col, 1'b0} : {1'b0, r_col};
    assign tap_r  = $signed({2'b00, rs}) - $signed(RC_W'(pr[1])) + $signed(RC_W'(ctrl.tap_i));
    assign tap_c  = $signed({2'b00, cs}) - $signed(RC_W'(pc[1])) + $signed(RC_W'(ctrl.tap_j));
    assign tap_ok = !tap_r[RC_W-1] && !tap_c[RC_W-1]
                    && (tap_r < $signed(RC_W'(h_dim)))
                    && (tap_c < $signed(RC_W'(w_dim)));
    assign rd_idx = IDX_W'(tap_r[DIM_W-1:0]) * IDX_W'(w_dim) + IDX_W'(tap_c[DIM_W-1:0]);
    assign raddr_wide = {{AW{1'b0}}, rd_idx};
    assign raddr      = raddr_wide[AW-1:0];

    dwc3_ram #(
        .WIDTH (SAMP_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (do_load),
        .i_waddr (waddr),
        .i_wdata (i_in_data.sample),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // ------------------------------------------------------------------
    // Multiply-accumulate
    // ------------------------------------------------------------------
    assign wrow = r_weight[r_tap_i];

    always_comb begin
        case (r_tap_j)
            2'd0:    weight = wrow[SAMP_W-1:0];
            2'd1:    weight = wrow[2*SAMP_W-1:SAMP_W];
            default: weight = wrow[3*SAMP_W-1:2*SAMP_W];
        endcase
    end

    // The product is formed on its own so that the multiply stays signed.
    assign product = rdata * weight;

    always_ff @(posedge i_clk) begin
        if (ctrl.rd) begin
            r_tap_i <= (ctrl.tap_i > 2'd2) ? 2'd2 : ctrl.tap_i;
            r_tap_j <= ctrl.tap_j;
        end
        if (ctrl.mul) begin
            r_product <= r_tap_valid ? product : '0;
        end
        if (start) begin
            r_acc <= '0;
        end else if (ctrl.acc) begin
            r_acc <= r_acc + SUM_W'(r_product);
        end
        if (emit) begin
            r_out.out_value <= r_acc;
            r_out.out_row   <= r_row[ROW_W-1:0];
            r_out.out_col   <= r_col[ROW_W-1:0];
            r_out.last      <= last;
        end
    end

    assign last = (r_row == oh_m1) && (r_col == ow_m1);

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= DIM_W'(64);
            r_image_height <= DIM_W'(64);
            r_stride_sel   <= 2'd1;
            r_pad_rows     <= 2'd2;
            r_pad_cols     <= 2'd2;
            r_weight[0]    <= '0;
            r_weight[1]    <= '0;
            r_weight[2]    <= '0;
            r_load_ptr     <= '0;
            r_row          <= '0;
            r_col          <= '0;
            r_tap_valid    <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    dwc3_pkg::CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[DIM_W-1:0];
                    dwc3_pkg::CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[DIM_W-1:0];
                    dwc3_pkg::CFG_STRIDE_SEL:   r_stride_sel   <= i_cfg_data[1:0];
                    dwc3_pkg::CFG_PAD_ROWS:     r_pad_rows     <= i_cfg_data[1:0];
                    dwc3_pkg::CFG_PAD_COLS:     r_pad_cols     <= i_cfg_data[1:0];
                    dwc3_pkg::CFG_WEIGHT_ROW0:  r_weight[0]    <= i_cfg_data;
                    dwc3_pkg::CFG_WEIGHT_ROW1:  r_weight[1]    <= i_cfg_data;
                    dwc3_pkg::CFG_WEIGHT_ROW2:  r_weight[2]    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (do_load) begin
                r_load_ptr <= (ld_next >= plane) ? '0 : ld_next;
            end

            if (ctrl.rd) begin
                r_tap_valid <= tap_ok;
            end

            // A stored position outside the current plane restarts at the origin.
            if (start) begin
                if ((r_row > oh_m1) || (r_col > ow_m1)) begin
                    r_row <= '0;
                    r_col <= '0;
                end
            end else if (emit) begin
                if (last) begin
                    r_row <= '0;
                    r_col <= '0;
                end else if (r_col == ow_m1) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end

            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = ctrl.accept;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
